/* design/gccc_pkg.sv */
// ----------------------------------------------------------------------------
// gccc_pkg
// Shared types and constants for the grid coprime conflict counter.
// ----------------------------------------------------------------------------
package gccc_pkg;

  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_LABEL_BITS = 12;

  localparam int COUNT_BITS = 13;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam int CFG_BITS     = 7;
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_BITS-1:0] SIZE_RESET = 7'd10;

  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_ROWS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_COLS = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_RUN,
    ST_WRAP
  } state_e;

  typedef struct packed {
    logic busy;
    logic hit;
  } gcd_stat_t;

endpackage

/* design/gccc_gcd.sv */
// ----------------------------------------------------------------------------
// gccc_gcd
// Iterative binary GCD test: flags whether two labels share a factor above 1.
// One reduction step per cycle.
// ----------------------------------------------------------------------------
module gccc_gcd #(
  parameter int LABEL_BITS = gccc_pkg::DEF_LABEL_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [LABEL_BITS-1:0] a_i,
  input  logic [LABEL_BITS-1:0] b_i,
  output gccc_pkg::gcd_stat_t   stat_o
);

  logic [LABEL_BITS-1:0] a_q, a_d, b_q, b_d;
  logic [LABEL_BITS-1:0] diff_ab, diff_ba;
  logic                  busy_q, hit_q, fin, hit_d;

  assign diff_ab = a_q - b_q;
  assign diff_ba = b_q - a_q;

  always_comb begin
    a_d   = a_q;
    b_d   = b_q;
    fin   = 1'b0;
    hit_d = 1'b0;
    if (a_q == '0) begin
      fin   = 1'b1;
      hit_d = (b_q > LABEL_BITS'(1));
    end else if (b_q == '0) begin
      fin   = 1'b1;
      hit_d = (a_q > LABEL_BITS'(1));
    end else if (!a_q[0] && !b_q[0]) begin
      fin   = 1'b1;
      hit_d = 1'b1;
    end else if (!a_q[0]) begin
      a_d = a_q >> 1;
    end else if (!b_q[0]) begin
      b_d = b_q >> 1;
    end else if (a_q >= b_q) begin
      a_d = diff_ab >> 1;
    end else begin
      b_d = diff_ba >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      hit_q  <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      hit_q  <= 1'b0;
    end else if (busy_q && fin) begin
      busy_q <= 1'b0;
      hit_q  <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.hit  = hit_q;

endmodule

/* design/grid_coprime_conflict_count_core.sv */
// ----------------------------------------------------------------------------
// grid_coprime_conflict_count_core
// Counts neighbouring grid cells (left and above) whose labels share a factor
// above 1; gives the count after the last cell of the configured grid.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------
//   in      | request   | in_valid_i/in_stall_o | cell_label_i
//   out     | result    | out_valid_o/out_stall_i | conflict_count_o
//   cfg     | write     | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// Each cell passes FETCH, RUN and WRAP before the next is taken in IDLE; RUN
// waits for the two parallel GCD runs, each one step per cycle.
// The previous row sits in a line memory read on acceptance, written at the end.
// Reset needs no clearing pass; the line memory is only used once written.
// The finished count waits in an output register; only a further grid end
// stalls on it.
// ----------------------------------------------------------------------------
module grid_coprime_conflict_count_core #(
  parameter int MAX_COLS   = gccc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = gccc_pkg::DEF_MAX_ROWS,
  parameter int LABEL_BITS = gccc_pkg::DEF_LABEL_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gccc_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [gccc_pkg::CFG_BITS-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [LABEL_BITS-1:0]               cell_label_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [gccc_pkg::COUNT_BITS-1:0]     conflict_count_o
);

  localparam int CPW = $clog2(MAX_COLS);
  localparam int RPW = $clog2(MAX_ROWS);
  localparam int CSW = $clog2(MAX_COLS + 1);
  localparam int RSW = $clog2(MAX_ROWS + 1);
  localparam int CB  = gccc_pkg::COUNT_BITS;

  gccc_pkg::state_e state_q, state_d;

  logic [gccc_pkg::CFG_BITS-1:0] grid_rows_q, grid_cols_q;
  logic [CSW-1:0]        cols_eff;
  logic [RSW-1:0]        rows_eff;
  logic [CPW-1:0]        col_q;
  logic [RPW-1:0]        row_q;
  logic [CB-1:0]         total_q, total_sat;
  logic [CB:0]           total_sum;
  logic [LABEL_BITS-1:0] label_q, left_q, rd_q;
  logic [LABEL_BITS-1:0] row_mem [MAX_COLS];
  logic                  en_left_q, en_up_q;
  logic                  out_valid_q;
  logic [CB-1:0]         out_count_q;

  logic in_acc, start, wrap_go, col_last, row_last, is_final, out_free, units_busy;
  gccc_pkg::gcd_stat_t stat_l, stat_u;

  gccc_gcd #(.LABEL_BITS(LABEL_BITS)) u_gcd_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start && en_left_q),
    .a_i     (left_q),
    .b_i     (label_q),
    .stat_o  (stat_l)
  );

  gccc_gcd #(.LABEL_BITS(LABEL_BITS)) u_gcd_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start && en_up_q),
    .a_i     (rd_q),
    .b_i     (label_q),
    .stat_o  (stat_u)
  );

  // zero sizes read as 1, oversize saturates
  assign cols_eff = (grid_cols_q == '0) ? CSW'(1) :
                    (32'(grid_cols_q) > MAX_COLS) ? CSW'(MAX_COLS) : CSW'(grid_cols_q);
  assign rows_eff = (grid_rows_q == '0) ? RSW'(1) :
                    (32'(grid_rows_q) > MAX_ROWS) ? RSW'(MAX_ROWS) : RSW'(grid_rows_q);

  assign col_last = (CSW'(col_q) + CSW'(1)) >= cols_eff;
  assign row_last = (RSW'(row_q) + RSW'(1)) >= rows_eff;
  assign is_final = col_last && row_last;
  assign out_free = !out_valid_q || !out_stall_i;
  assign units_busy = stat_l.busy || stat_u.busy;

  assign total_sum = {1'b0, total_q} + (CB+1)'(en_left_q && stat_l.hit)
                   + (CB+1)'(en_up_q && stat_u.hit);
  assign total_sat = (total_sum > {1'b0, gccc_pkg::COUNT_MAX}) ? gccc_pkg::COUNT_MAX
                                                               : total_sum[CB-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      gccc_pkg::ST_IDLE:  if (in_valid_i) state_d = gccc_pkg::ST_FETCH;
      gccc_pkg::ST_FETCH: state_d = gccc_pkg::ST_RUN;
      gccc_pkg::ST_RUN:   if (!units_busy) state_d = gccc_pkg::ST_WRAP;
      gccc_pkg::ST_WRAP:  if (!is_final || out_free) state_d = gccc_pkg::ST_IDLE;
      default:            state_d = gccc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    start      = 1'b0;
    wrap_go    = 1'b0;
    case (state_q)
      gccc_pkg::ST_IDLE:  in_stall_o = 1'b0;
      gccc_pkg::ST_FETCH: start = 1'b1;
      gccc_pkg::ST_RUN:   ;
      gccc_pkg::ST_WRAP:  wrap_go = !is_final || out_free;
      default:            ;
    endcase
  end

  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gccc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= gccc_pkg::SIZE_RESET;
      grid_cols_q <= gccc_pkg::SIZE_RESET;
      col_q       <= '0;
      row_q       <= '0;
      total_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gccc_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_wdata_i;
        gccc_pkg::REG_GRID_COLS: grid_cols_q <= cfg_wdata_i;
        default: ;
      endcase
      col_q   <= '0;
      row_q   <= '0;
      total_q <= '0;
    end else if (wrap_go) begin
      if (col_last) begin
        col_q <= '0;
        if (row_last) begin
          row_q   <= '0;
          total_q <= '0;
        end else begin
          row_q   <= row_q + RPW'(1);
          total_q <= total_sat;
        end
      end else begin
        col_q   <= col_q + CPW'(1);
        total_q <= total_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wrap_go && is_final) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wrap_go && is_final) begin
      out_count_q <= total_sat;
    end
  end

  // request capture and line memory
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      label_q   <= cell_label_i;
      rd_q      <= row_mem[col_q];
      en_left_q <= (col_q != '0);
      en_up_q   <= (row_q != '0);
    end
    if (wrap_go) begin
      row_mem[col_q] <= label_q;
      left_q         <= label_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign conflict_count_o = out_count_q;

`ifndef NO_ASSERTIONS
  a_out_from_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == gccc_pkg::ST_WRAP))
    else $error("result raised outside grid end");

  a_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gccc_pkg::ST_IDLE) |-> !units_busy)
    else $error("gcd unit busy while idle");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CSW'(col_q) < cols_eff)
    else $error("column position beyond grid");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    RSW'(row_q) < rows_eff)
    else $error("row position beyond grid");
`endif

endmodule

/* tb/gccc_conflict_checker.sv */
// ----------------------------------------------------------------------------
// gccc_conflict_checker
// Watches the write port and both channels of the conflict counter, keeps its
// own copy of grid sizes, line store and running count, and compares every
// delivered conflict count with the oldest predicted one.
// ----------------------------------------------------------------------------
module gccc_conflict_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [gccc_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [gccc_pkg::CFG_BITS-1:0]         cfg_wdata_i,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic [gccc_pkg::DEF_LABEL_BITS-1:0]   cell_label_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic [gccc_pkg::COUNT_BITS-1:0]       conflict_count_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);

  localparam int LABEL_W = gccc_pkg::DEF_LABEL_BITS;
  localparam int CFG_W   = gccc_pkg::CFG_BITS;
  localparam int COUNT_W = gccc_pkg::COUNT_BITS;

  logic [CFG_W-1:0]   rows_raw;
  logic [CFG_W-1:0]   cols_raw;
  logic [LABEL_W-1:0] above_row [gccc_pkg::DEF_MAX_COLS];
  logic [LABEL_W-1:0] left_lbl;
  int                 col_at;
  int                 row_at;
  logic [COUNT_W-1:0] tally;
  logic [COUNT_W-1:0] counts_due [$];
  int                 errs;

  function automatic logic [LABEL_W-1:0] shared_factor(
    logic [LABEL_W-1:0] a,
    logic [LABEL_W-1:0] b
  );
    logic [LABEL_W-1:0] t;
    while (b != '0) begin
      t = b;
      b = a % b;
      a = t;
    end
    return a;
  endfunction

  function automatic int span_in_use(logic [CFG_W-1:0] v, int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  task automatic restart_grid();
    col_at = 0;
    row_at = 0;
    tally  = '0;
  endtask

  task automatic bump_tally();
    if (tally != gccc_pkg::COUNT_MAX) tally = tally + 1'b1;
  endtask

  task automatic take_cell(input logic [LABEL_W-1:0] lbl);
    int rows;
    int cols;
    int c;
    rows = span_in_use(rows_raw, gccc_pkg::DEF_MAX_ROWS);
    cols = span_in_use(cols_raw, gccc_pkg::DEF_MAX_COLS);
    c    = col_at % gccc_pkg::DEF_MAX_COLS;
    if (c > 0 && shared_factor(left_lbl, lbl) > 1) bump_tally();
    if (row_at > 0 && shared_factor(above_row[c], lbl) > 1) bump_tally();
    above_row[c] = lbl;
    left_lbl     = lbl;
    if (c + 1 >= cols) begin
      col_at = 0;
      if (row_at + 1 >= rows) begin
        counts_due.push_back(tally);
        restart_grid();
      end else begin
        row_at = row_at + 1;
      end
    end else begin
      col_at = c + 1;
    end
  endtask

  always @(posedge clk_i) begin : watch
    logic [COUNT_W-1:0] want;
    if (!rst_ni) begin
      rows_raw = gccc_pkg::SIZE_RESET;
      cols_raw = gccc_pkg::SIZE_RESET;
      foreach (above_row[i]) above_row[i] = '0;
      left_lbl = '0;
      restart_grid();
      counts_due.delete();
      errs = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (counts_due.size() == 0) begin
          $error("conflict_count: expected none, actual %0d", conflict_count_i);
          errs = errs + 1;
        end else begin
          want = counts_due.pop_front();
          if (conflict_count_i !== want) begin
            $error("conflict_count: expected %0d, actual %0d", want, conflict_count_i);
            errs = errs + 1;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gccc_pkg::REG_GRID_ROWS: rows_raw = cfg_wdata_i;
          gccc_pkg::REG_GRID_COLS: cols_raw = cfg_wdata_i;
          default: ;
        endcase
        restart_grid();
      end
      if (in_valid_i && !in_stall_i) take_cell(cell_label_i);
    end
    pending_o    <= counts_due.size();
    fail_count_o <= errs;
  end

endmodule

/* tb/tb_grid_coprime_conflict_count_core.sv */
// ----------------------------------------------------------------------------
// tb_grid_coprime_conflict_count_core
// Feeds grids of cell labels to the conflict counter: a few hand-picked grids
// (zero and all-ones labels, size registers at zero, restart mid-grid), then
// random phases of grid sizes, label mixes and cut-short grids. The sender
// runs in bursts, the receiver stalls on its own pattern; a checker beside
// the block predicts and compares every count.
// ----------------------------------------------------------------------------
module tb_grid_coprime_conflict_count_core;

  localparam int IDLE_LIMIT   = 3000;
  localparam int SETTLE_TICKS = 40;
  localparam int RANDOM_CELLS = 1200;

  localparam int LABEL_W = gccc_pkg::DEF_LABEL_BITS;
  localparam int CFG_W   = gccc_pkg::CFG_BITS;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [gccc_pkg::CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [CFG_W-1:0]                  cfg_wdata_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [LABEL_W-1:0]                cell_label_i;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic [gccc_pkg::COUNT_BITS-1:0]   conflict_count_o;

  int fail_count;
  int pending;

  logic [CFG_W-1:0] rows_raw;
  logic [CFG_W-1:0] cols_raw;
  bit               drv_valid;
  int               burst_left;
  int               cells_sent;

  int stall_left = 0;
  int stall_mode = 0;
  int idle_cycles = 0;

  grid_coprime_conflict_count_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cell_label_i    (cell_label_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .conflict_count_o(conflict_count_o)
  );

  gccc_conflict_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .cell_label_i    (cell_label_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .conflict_count_i(conflict_count_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always #4 clk_i = ~clk_i;

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(10, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= 1'($urandom_range(0, 1));
      2: out_stall_i <= 1'b1;
      default: out_stall_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("grid_coprime_conflict_count_core test failed");
        $finish;
      end
    end
  end

  function automatic int span_of(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > gccc_pkg::DEF_MAX_COLS) return gccc_pkg::DEF_MAX_COLS;
    return int'(v);
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label(int mix);
    int k;
    logic [LABEL_W-1:0] v;
    case (mix)
      0: v = LABEL_W'($urandom_range(0, 4095));
      1: v = LABEL_W'($urandom_range(0, 15));
      2: begin
        case ($urandom_range(0, 3))
          0: k = 2;
          1: k = 3;
          2: k = 5;
          default: k = 7;
        endcase
        v = LABEL_W'($urandom_range(0, 4095 / k) * k);
      end
      default: begin
        case ($urandom_range(0, 5))
          0: v = 12'd0;
          1: v = 12'd1;
          2: v = 12'd4095;
          3: v = 12'd4094;
          4: v = 12'd2048;
          default: v = 12'd4093;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_cell(input logic [LABEL_W-1:0] lbl);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid_i   <= 1'b1;
    cell_label_i <= lbl;
    drv_valid     = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    cells_sent = cells_sent + 1;
    burst_left = burst_left - 1;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      drv_valid   = 1'b0;
    end
  endtask

  // drop valid, wait for every count to arrive and the block to go quiet
  task automatic settle();
    if (drv_valid) begin
      in_valid_i <= 1'b0;
      drv_valid   = 1'b0;
    end
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic program_grid(input bit set_rows, input bit set_cols,
                              input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
    settle();
    if (set_rows) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= gccc_pkg::REG_GRID_ROWS;
      cfg_wdata_i <= r;
      @(posedge clk_i);
      rows_raw = r;
    end
    if (set_cols) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= gccc_pkg::REG_GRID_COLS;
      cfg_wdata_i <= c;
      @(posedge clk_i);
      cols_raw = c;
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_grid(input int cells);
    int mix;
    mix = $urandom_range(0, 5);
    if (mix > 3) mix = 0;
    for (int k = 0; k < cells; k++) send_cell(pick_label(mix));
  endtask

  initial begin
    int kind;
    int cells;
    int grids;
    bit set_r;
    bit set_c;
    logic [CFG_W-1:0] r;
    logic [CFG_W-1:0] c;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = gccc_pkg::REG_GRID_ROWS;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    cell_label_i = '0;
    rows_raw     = gccc_pkg::SIZE_RESET;
    cols_raw     = gccc_pkg::SIZE_RESET;
    drv_valid    = 1'b0;
    burst_left   = 0;
    cells_sent   = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // default size, cut short by the next write
    send_cell(12'd0);
    send_cell(12'd0);
    send_cell(12'd4095);
    send_cell(12'd4095);
    // zero sizes act as one cell per grid
    program_grid(1'b1, 1'b1, 7'd0, 7'd0);
    send_cell(12'd0);
    send_cell(12'd4095);
    send_cell(12'd1);
    // zero next to a factor counts, two zeros do not
    program_grid(1'b1, 1'b1, 7'd2, 7'd2);
    send_cell(12'd0);
    send_cell(12'd2);
    send_cell(12'd0);
    send_cell(12'd3);
    repeat (4) send_cell(12'd4095);
    program_grid(1'b1, 1'b1, 7'd1, 7'd3);
    send_cell(12'd6);
    send_cell(12'd10);
    send_cell(12'd15);
    program_grid(1'b0, 1'b1, 7'd1, 7'd4);
    send_cell(12'd4093);
    send_cell(12'd4094);
    send_cell(12'd0);
    send_cell(12'd0);

    cells_sent = 0;
    while (cells_sent < RANDOM_CELLS) begin
      kind  = $urandom_range(0, 15);
      set_r = 1'b1;
      set_c = 1'b1;
      r     = CFG_W'($urandom_range(1, 6));
      c     = CFG_W'($urandom_range(1, 6));
      case (kind)
        0: r = 7'd0;
        1: c = 7'd0;
        2: begin
          r = CFG_W'($urandom_range(65, 127));
          c = CFG_W'($urandom_range(0, 2));
        end
        3: begin
          r = CFG_W'($urandom_range(0, 2));
          c = CFG_W'($urandom_range(65, 127));
        end
        4: begin
          r = 7'd64;
          c = 7'd1;
        end
        5: begin
          r = 7'd1;
          c = 7'd64;
        end
        6: begin
          set_c = 1'b0;
          c     = cols_raw;
        end
        7: begin
          set_r = 1'b0;
          r     = rows_raw;
        end
        8: begin
          r = 7'd10;
          c = 7'd10;
        end
        default: ;
      endcase
      program_grid(set_r, set_c, r, c);
      cells = span_of(rows_raw) * span_of(cols_raw);
      if (cells <= 16) grids = $urandom_range(1, 5);
      else if (cells <= 64) grids = $urandom_range(1, 2);
      else grids = 1;
      repeat (grids) send_grid(cells);
      // broken grid, restarted by the next write
      if (cells > 1 && $urandom_range(0, 4) == 0) send_grid($urandom_range(1, cells - 1));
    end

    settle();
    if (fail_count == 0) begin
      $display("grid_coprime_conflict_count_core test passed");
    end else begin
      $display("grid_coprime_conflict_count_core test failed");
    end
    $finish;
  end

endmodule
